// ----- rtl/decimated_history_ring_buffer_defines.svh -----
// ----------------------------------------------------------------------------
// Decimated history ring buffer: assertion macros
// Wrappers for the concurrent checks of the ring buffer modules.
// ----------------------------------------------------------------------------
`ifndef DECIMATED_HISTORY_RING_BUFFER_DEFINES_SVH
`define DECIMATED_HISTORY_RING_BUFFER_DEFINES_SVH

// Check clocked on clk, off while rst_n is low.
`define DHRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check clocked on clk, also active during reset.
`define DHRB_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dhrb_pkg.sv -----
// ----------------------------------------------------------------------------
// dhrb_pkg
// Types and constants shared by the decimated history ring buffer modules.
// ----------------------------------------------------------------------------
package dhrb_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int STATE_BITS  = 32;
  localparam int COUNT_BITS  = 48;
  localparam int CAP_W       = 6;
  localparam int SAVE_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap naturally

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(63);
  localparam logic [SAVE_W-1:0] SAVE_RESET = SAVE_W'(1);

  typedef enum logic [1:0] {
    MODE_MAYBE_SAVE  = 2'd0,
    MODE_ALWAYS_SAVE = 2'd1,
    MODE_DRAIN       = 2'd2,
    MODE_CLEAR       = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_CAPACITY   = 1'b0,
    REG_SAVE_EVERY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_MAYBE,
    CMD_ALWAYS,
    CMD_DRAIN,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    mode_t                 mode;
    logic [STATE_BITS-1:0] state_word;
    logic [COUNT_BITS-1:0] iteration_count;
    logic [COUNT_BITS-1:0] output_count;
    logic                  final_halted;
    logic                  final_hit_limit;
  } in_beat_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] entry_state;
    logic [COUNT_BITS-1:0] entry_iterations;
    logic [COUNT_BITS-1:0] entry_output;
    logic                  entry_halted;
    logic                  entry_hit_limit;
    logic                  last_entry;
  } out_beat_t;

  // Classified command passed from front to back.
  typedef struct packed {
    cmd_t                  cmd;
    logic [STATE_BITS-1:0] state_word;
    logic [COUNT_BITS-1:0] iterations;
    logic [COUNT_BITS-1:0] outputs;
    logic                  halted;
    logic                  hit_limit;
  } qent_t;

endpackage

// ----- rtl/decimated_history_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// decimated_history_ring_buffer
// History ring of snapshots with decimated saves and oldest-first drain.
// ----------------------------------------------------------------------------
// Input beats go into a two-deep command queue and the back end takes one
// command per cycle while no drain is running, so save and clear beats run
// at one per cycle sustained. A drain holds the back end until its last
// entry is loaded; each entry is read on the snapshot RAM's registered port
// (ST_READ) and then loaded into the output register (ST_EMIT), which stalls
// the sequence while out_ready is low. Input beats keep queueing behind a
// drain until the queue is full. Config writes are taken at any cycle but
// are meant for an idle block; writing capacity_in_use empties the ring,
// writing save_every reloads the decimation count.
module decimated_history_ring_buffer #(
  parameter int SLOTS = dhrb_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dhrb_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dhrb_pkg::out_beat_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  dhrb_pkg::cfg_reg_t              cfg_index,
  input  logic [dhrb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dhrb_pkg::*;

  logic  q_valid;
  logic  q_pop;
  qent_t q_data;

  dhrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  dhrb_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/dhrb_ram.sv -----
// ----------------------------------------------------------------------------
// dhrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dhrb_front.sv -----
// ----------------------------------------------------------------------------
// dhrb_front
// Accepts input beats, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module dhrb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dhrb_pkg::in_beat_t in_data,
  output logic               q_valid,
  output dhrb_pkg::qent_t    q_data,
  input  logic               q_pop
);
  import dhrb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  qent_t            classified;

  function automatic cmd_t to_cmd(mode_t m);
    cmd_t c;
    unique case (m)
      MODE_MAYBE_SAVE:  c = CMD_MAYBE;
      MODE_ALWAYS_SAVE: c = CMD_ALWAYS;
      MODE_DRAIN:       c = CMD_DRAIN;
      MODE_CLEAR:       c = CMD_CLEAR;
      default:          c = CMD_CLEAR;
    endcase
    return c;
  endfunction

  always_comb begin
    classified.cmd        = to_cmd(in_data.mode);
    classified.state_word = in_data.state_word;
    classified.iterations = in_data.iteration_count;
    classified.outputs    = in_data.output_count;
    classified.halted     = in_data.final_halted;
    classified.hit_limit  = in_data.final_hit_limit;
  end

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_data   = q_mem[rd_ptr_r];

  always_comb begin
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
    if (push) begin
      q_mem[wr_ptr_r] <= classified;
    end
  end

endmodule

// ----- rtl/dhrb_back.sv -----
// ----------------------------------------------------------------------------
// dhrb_back
// Ring pointers, decimation counter, snapshot RAM and the drain sequencer.
// ----------------------------------------------------------------------------
`include "decimated_history_ring_buffer_defines.svh"

module dhrb_back #(
  parameter int SLOTS = dhrb_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  dhrb_pkg::qent_t                     q_data,
  output logic                                q_pop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  dhrb_pkg::cfg_reg_t                  cfg_index,
  input  logic [dhrb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dhrb_pkg::out_beat_t                 out_data
);
  import dhrb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = STATE_BITS + 2 * COUNT_BITS;
  localparam logic [CAP_W:0] MAX_LAST = (CAP_W + 1)'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      last_idx_r, last_idx_nxt;
  logic [SAVE_W-1:0]     reload_r, reload_nxt;
  logic [SAVE_W-1:0]     calls_left_r, calls_left_nxt;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [IDX_W-1:0]      next_r, next_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [COUNT_BITS-1:0] fin_iter_r, fin_iter_nxt;
  logic [COUNT_BITS-1:0] fin_out_r, fin_out_nxt;
  logic                  halted_r, halted_nxt;
  logic                  limit_r, limit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  logic                  ram_we, ram_re;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic                  do_rec;
  logic [SAVE_W-1:0]     cl_dec;
  logic [IDX_W-1:0]      rec_next, rd_next;
  logic [STATE_BITS-1:0] rd_state;
  logic [COUNT_BITS-1:0] rd_iter, rd_out;
  logic [SAVE_W-1:0]     cfg_save;

  // Effective capacity (0 acts as 1, clamp to SLOTS-1) is the last slot index.
  function automatic logic [IDX_W-1:0] cap_to_last(logic [CAP_W-1:0] c);
    logic [CAP_W:0] v;
    v = {1'b0, c};
    if (v == '0) begin
      v = (CAP_W + 1)'(1);
    end
    if (v > MAX_LAST) begin
      v = MAX_LAST;
    end
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] x,
                                                logic [IDX_W-1:0] last);
    return (x == last) ? '0 : x + IDX_W'(1);
  endfunction

  dhrb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {q_data.state_word, q_data.iterations, q_data.outputs};
  assign {rd_state, rd_iter, rd_out} = ram_rdata;
  assign cl_dec    = calls_left_r - SAVE_W'(1);
  assign rec_next  = wrap_inc(next_r, last_idx_r);
  assign rd_next   = wrap_inc(rd_idx_r, last_idx_r);
  assign cfg_save  = (cfg_data[SAVE_W-1:0] == '0) ? SAVE_W'(1) : cfg_data[SAVE_W-1:0];
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    last_idx_nxt   = last_idx_r;
    reload_nxt     = reload_r;
    calls_left_nxt = calls_left_r;
    oldest_nxt     = oldest_r;
    next_nxt       = next_r;
    rd_idx_nxt     = rd_idx_r;
    fin_iter_nxt   = fin_iter_r;
    fin_out_nxt    = fin_out_r;
    halted_nxt     = halted_r;
    limit_nxt      = limit_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    do_rec         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_data.cmd)
            CMD_MAYBE: begin
              if (cl_dec == '0) begin
                do_rec = 1'b1;
              end else begin
                calls_left_nxt = cl_dec;
              end
            end
            CMD_ALWAYS: begin
              do_rec = 1'b1;
            end
            CMD_CLEAR: begin
              oldest_nxt     = '0;
              next_nxt       = '0;
              calls_left_nxt = reload_r;
            end
            CMD_DRAIN: begin
              if (oldest_r != next_r) begin
                fin_iter_nxt = q_data.iterations;
                fin_out_nxt  = q_data.outputs;
                halted_nxt   = q_data.halted;
                limit_nxt    = q_data.hit_limit;
                rd_idx_nxt   = oldest_r;
                state_nxt    = ST_READ;
              end
            end
            default: ;
          endcase
        end
        if (do_rec) begin
          // Write at next; if the ring was full, push oldest forward past the dropped entry.
          ram_we         = 1'b1;
          next_nxt       = rec_next;
          calls_left_nxt = reload_r;
          if (oldest_r == rec_next) begin
            oldest_nxt = wrap_inc(rec_next, last_idx_r);
          end
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.entry_state     = rd_state;
          out_data_nxt.entry_iterations = halted_r ? fin_iter_r - rd_iter : rd_iter;
          out_data_nxt.entry_output    = halted_r ? fin_out_r - rd_out : rd_out;
          out_data_nxt.entry_halted    = halted_r;
          out_data_nxt.entry_hit_limit = limit_r;
          out_data_nxt.last_entry      = (rd_next == next_r);
          rd_idx_nxt                   = rd_next;
          state_nxt                    = (rd_next == next_r) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Config writes are to arrive only while the block is idle; the block itself does not enforce it.
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          last_idx_nxt = cap_to_last(cfg_data[CAP_W-1:0]);
          oldest_nxt   = '0;
          next_nxt     = '0;
        end
        REG_SAVE_EVERY: begin
          reload_nxt     = cfg_save;
          calls_left_nxt = cfg_save;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_idx_r   <= cap_to_last(CAP_RESET);
      reload_r     <= SAVE_RESET;
      calls_left_r <= SAVE_RESET;
      oldest_r     <= '0;
      next_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_idx_r   <= last_idx_nxt;
      reload_r     <= reload_nxt;
      calls_left_r <= calls_left_nxt;
      oldest_r     <= oldest_nxt;
      next_r       <= next_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    fin_iter_r <= fin_iter_nxt;
    fin_out_r  <= fin_out_nxt;
    halted_r   <= halted_nxt;
    limit_r    <= limit_nxt;
    out_data_r <= out_data_nxt;
  end

  `DHRB_ASSERT_ANY(a_reset_idle, !rst_n |=> state_r == ST_IDLE && !out_valid_r, "reset busy")
  `DHRB_ASSERT(a_ptr_range, oldest_r <= last_idx_r && next_r <= last_idx_r, "pointer past ring")
  `DHRB_ASSERT(a_calls_nonzero, calls_left_r != '0, "decimation counter reached zero")
  `DHRB_ASSERT(a_write_idle, (ram_we || q_pop) |-> state_r == ST_IDLE, "busy write")
  `DHRB_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r) == ST_EMIT, "stray result")

endmodule
